FILE: design/plane_index_zct_converter_assert.svh
// Assertion macros used by the checker file pizc_checker.sv.
`ifndef PLANE_INDEX_ZCT_CONVERTER_ASSERT_SVH
`define PLANE_INDEX_ZCT_CONVERTER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PIZC_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PIZC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: design/pizc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pizc_pkg;

   localparam int COORD_BITS_DEF = 16;

   typedef enum logic [1:0] {
      AXIS_Z = 2'd0,
      AXIS_C = 2'd1,
      AXIS_T = 2'd2
   } axis_type;

   localparam logic [2:0] ORDER_ZCT = 3'd0;
   localparam logic [2:0] ORDER_ZTC = 3'd1;
   localparam logic [2:0] ORDER_CZT = 3'd2;
   localparam logic [2:0] ORDER_CTZ = 3'd3;
   localparam logic [2:0] ORDER_TZC = 3'd4;
   localparam logic [2:0] ORDER_TCZ = 3'd5;

   localparam logic [1:0] REG_AXIS_ORDER    = 2'd0;
   localparam logic [1:0] REG_DEPTH_COUNT   = 2'd1;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
   localparam logic [1:0] REG_TIME_COUNT    = 2'd3;

   typedef struct packed {
      logic [15:0] rem;
      logic [47:0] nq;
      logic [15:0] dvs;
   } div_type;

   typedef struct packed {
      logic        func;
      logic        err;
      logic [2:0]  order;
      logic [47:0] index;
      logic [15:0] len1;
      logic [15:0] rem0;
   } side_type;

   // Axis at a digit position, fastest first.
   function automatic axis_type axis_of(input logic [2:0] order, input logic [1:0] pos);
      axis_type a0;
      axis_type a1;
      axis_type a2;
      case (order)
         ORDER_ZTC: begin a0 = AXIS_Z; a1 = AXIS_T; a2 = AXIS_C; end
         ORDER_CZT: begin a0 = AXIS_C; a1 = AXIS_Z; a2 = AXIS_T; end
         ORDER_CTZ: begin a0 = AXIS_C; a1 = AXIS_T; a2 = AXIS_Z; end
         ORDER_TZC: begin a0 = AXIS_T; a1 = AXIS_Z; a2 = AXIS_C; end
         ORDER_TCZ: begin a0 = AXIS_T; a1 = AXIS_C; a2 = AXIS_Z; end
         default:   begin a0 = AXIS_Z; a1 = AXIS_C; a2 = AXIS_T; end
      endcase
      case (pos)
         2'd0:    return a0;
         2'd1:    return a1;
         default: return a2;
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: design/pizc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pizc_front #(
   parameter int COORD_BITS = pizc_pkg::COORD_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic               func,
   input  wire logic [15:0]        z_in,
   input  wire logic [15:0]        c_in,
   input  wire logic [15:0]        t_in,
   input  wire logic [47:0]        index_in,
   input  wire logic [2:0]         axis_order,
   input  wire logic [15:0]        depth_count,
   input  wire logic [15:0]        channel_count,
   input  wire logic [15:0]        time_count,
   output logic                    out_valid,
   output pizc_pkg::div_type       out_div,
   output pizc_pkg::side_type      out_side
);
   import pizc_pkg::*;

   localparam logic [15:0] CMASK = (COORD_BITS >= 16) ? 16'hFFFF :
                                   16'((32'd1 << COORD_BITS) - 32'd1);

   logic [15:0] size_w [3];
   logic [15:0] coord_w [3];
   logic [15:0] len_in [3];
   logic [15:0] p_in [3];
   logic        err_in;

   logic [3:0]  valid_ff;
   logic        func_ff [3];
   logic        err_ff [3];
   logic [2:0]  order_ff [3];
   logic [47:0] idx_ff [3];
   logic [15:0] len0_ff [3];
   logic [15:0] len1_ff [3];
   logic [15:0] len2_ff [2];
   logic [15:0] p0_ff [2];
   logic [15:0] p1_ff;
   logic [15:0] p2_ff;
   logic [31:0] m1_ff;
   logic [31:0] m2_ff;
   logic [31:0] l01_ff;
   logic [32:0] sum1_ff;
   logic [47:0] m2b_ff;
   logic [47:0] tot_ff;
   logic [48:0] sum_w;
   side_type    side_ff;
   div_type     div_ff;

   always_comb begin
      err_in = 1'b0;
      size_w[0] = depth_count & CMASK;
      size_w[1] = channel_count & CMASK;
      size_w[2] = time_count & CMASK;
      coord_w[0] = z_in & CMASK;
      coord_w[1] = c_in & CMASK;
      coord_w[2] = t_in & CMASK;
      for (int i = 0; i < 3; i++) begin
         if (size_w[i] == 16'd0) begin
            err_in = 1'b1;
            size_w[i] = 16'd1;
         end
         if (!func && coord_w[i] >= size_w[i]) begin
            err_in = 1'b1;
         end
      end
      for (int i = 0; i < 3; i++) begin
         case (axis_of(axis_order, 2'(i)))
            AXIS_Z:  begin len_in[i] = size_w[0]; p_in[i] = coord_w[0]; end
            AXIS_C:  begin len_in[i] = size_w[1]; p_in[i] = coord_w[1]; end
            default: begin len_in[i] = size_w[2]; p_in[i] = coord_w[2]; end
         endcase
      end
   end

   assign sum_w = {16'd0, sum1_ff} + {1'b0, m2b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         func_ff[0]  <= func;
         err_ff[0]   <= err_in;
         order_ff[0] <= axis_order;
         idx_ff[0]   <= index_in;
         len0_ff[0]  <= len_in[0];
         len1_ff[0]  <= len_in[1];
         len2_ff[0]  <= len_in[2];
         p0_ff[0]    <= p_in[0];
         p1_ff       <= p_in[1];
         p2_ff       <= p_in[2];

         m1_ff       <= p1_ff * len0_ff[0];
         m2_ff       <= p2_ff * len0_ff[0];
         l01_ff      <= len0_ff[0] * len1_ff[0];
         func_ff[1]  <= func_ff[0];
         err_ff[1]   <= err_ff[0];
         order_ff[1] <= order_ff[0];
         idx_ff[1]   <= idx_ff[0];
         len0_ff[1]  <= len0_ff[0];
         len1_ff[1]  <= len1_ff[0];
         len2_ff[1]  <= len2_ff[0];
         p0_ff[1]    <= p0_ff[0];

         sum1_ff     <= {17'd0, p0_ff[1]} + {1'b0, m1_ff};
         m2b_ff      <= m2_ff * len1_ff[1];
         tot_ff      <= l01_ff * len2_ff[1];
         func_ff[2]  <= func_ff[1];
         err_ff[2]   <= err_ff[1];
         order_ff[2] <= order_ff[1];
         idx_ff[2]   <= idx_ff[1];
         len0_ff[2]  <= len0_ff[1];
         len1_ff[2]  <= len1_ff[1];

         side_ff.len1  <= len1_ff[2];
         side_ff.func  <= func_ff[2];
         side_ff.order <= order_ff[2];
         side_ff.index <= sum_w[47:0];
         side_ff.rem0  <= 16'd0;
         side_ff.err   <= err_ff[2] | (func_ff[2] ? (idx_ff[2] >= tot_ff) : sum_w[48]);
         div_ff.rem    <= 16'd0;
         div_ff.nq     <= idx_ff[2];
         div_ff.dvs    <= len0_ff[2];
      end
   end

   assign out_valid = valid_ff[3];
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

FILE: design/pizc_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module pizc_div_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  pizc_pkg::div_type       in_div,
   input  pizc_pkg::side_type      in_side,
   output logic                    out_valid,
   output pizc_pkg::div_type       out_div,
   output pizc_pkg::side_type      out_side
);
   import pizc_pkg::*;

   logic [16:0] trial;
   logic [16:0] diff;
   logic        ge;
   div_type     div_in;
   logic        valid_ff;
   div_type     div_ff;
   side_type    side_ff;

   always_comb begin
      trial = {in_div.rem, in_div.nq[47]};
      diff = trial - {1'b0, in_div.dvs};
      ge = trial >= {1'b0, in_div.dvs};
      div_in.rem = ge ? diff[15:0] : trial[15:0];
      div_in.nq = {in_div.nq[46:0], ge};
      div_in.dvs = in_div.dvs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff  <= div_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

FILE: design/pizc_div_chain.sv
`timescale 1ns / 1ps
`default_nettype none
module pizc_div_chain #(
   parameter int STEPS = 48
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  pizc_pkg::div_type       in_div,
   input  pizc_pkg::side_type      in_side,
   output logic                    out_valid,
   output pizc_pkg::div_type       out_div,
   output pizc_pkg::side_type      out_side
);
   import pizc_pkg::*;

   logic     valid_w [STEPS+1];
   div_type  div_w [STEPS+1];
   side_type side_w [STEPS+1];

   assign valid_w[0] = in_valid;
   assign div_w[0]   = in_div;
   assign side_w[0]  = in_side;

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      pizc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (valid_w[i]),
         .in_div    (div_w[i]),
         .in_side   (side_w[i]),
         .out_valid (valid_w[i+1]),
         .out_div   (div_w[i+1]),
         .out_side  (side_w[i+1])
      );
   end

   assign out_valid = valid_w[STEPS];
   assign out_div   = div_w[STEPS];
   assign out_side  = side_w[STEPS];

endmodule
`default_nettype wire

FILE: design/plane_index_zct_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// Converts (z, channel, time) coordinates to a linear plane index (tuser 0) or a plane index
// back to coordinates (tuser 1) under the configured axis order. One request is accepted
// every cycle while the output is not stalled. A request passes through the multiply and
// range check front end, then two chains of 48 division cells that each retire one quotient
// bit per cycle, then the output register. A stalled output holds the whole pipeline.
module plane_index_zct_converter #(
   parameter int COORD_BITS = pizc_pkg::COORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // z_in, c_in, t_in, index_in
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // index_out, z_out, c_out, t_out
   output logic             rsp_tuser,   // range_error
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import pizc_pkg::*;

   localparam logic [15:0] CMASK = (COORD_BITS >= 16) ? 16'hFFFF :
                                   16'((32'd1 << COORD_BITS) - 32'd1);

   logic [2:0]  axis_order_ff;
   logic [15:0] depth_count_ff;
   logic [15:0] channel_count_ff;
   logic [15:0] time_count_ff;
   logic        adv;
   logic        wr;

   logic        f_valid;
   div_type     f_div;
   side_type    f_side;
   logic        a_valid;
   div_type     a_div;
   side_type    a_side;
   div_type     b_div_in;
   side_type    b_side_in;
   logic        b_valid;
   div_type     b_div;
   side_type    b_side;

   logic [15:0] digit [3];
   logic [15:0] z_w;
   logic [15:0] c_w;
   logic [15:0] t_w;
   logic [95:0] data_in;
   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;
   logic        rsp_err_ff;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_order_ff    <= ORDER_ZCT;
         depth_count_ff   <= 16'd1;
         channel_count_ff <= 16'd1;
         time_count_ff    <= 16'd1;
      end else if (wr) begin
         case (csr_paddr[3:2])
            REG_AXIS_ORDER:    axis_order_ff    <= csr_pwdata[2:0];
            REG_DEPTH_COUNT:   depth_count_ff   <= csr_pwdata[15:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_pwdata[15:0];
            REG_TIME_COUNT:    time_count_ff    <= csr_pwdata[15:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_AXIS_ORDER:    csr_prdata = {29'd0, axis_order_ff};
         REG_DEPTH_COUNT:   csr_prdata = {16'd0, depth_count_ff};
         REG_CHANNEL_COUNT: csr_prdata = {16'd0, channel_count_ff};
         REG_TIME_COUNT:    csr_prdata = {16'd0, time_count_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign adv = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   pizc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_tvalid),
      .func          (req_tuser),
      .z_in          (req_tdata[15:0]),
      .c_in          (req_tdata[31:16]),
      .t_in          (req_tdata[47:32]),
      .index_in      (req_tdata[95:48]),
      .axis_order    (axis_order_ff),
      .depth_count   (depth_count_ff),
      .channel_count (channel_count_ff),
      .time_count    (time_count_ff),
      .out_valid     (f_valid),
      .out_div       (f_div),
      .out_side      (f_side)
   );

   pizc_div_chain #(.STEPS(48)) u_chain_a (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_div    (f_div),
      .in_side   (f_side),
      .out_valid (a_valid),
      .out_div   (a_div),
      .out_side  (a_side)
   );

   always_comb begin
      b_side_in = a_side;
      b_side_in.rem0 = a_div.rem;
      b_div_in.rem = 16'd0;
      b_div_in.nq = a_div.nq;
      b_div_in.dvs = a_side.len1;
   end

   pizc_div_chain #(.STEPS(48)) u_chain_b (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (a_valid),
      .in_div    (b_div_in),
      .in_side   (b_side_in),
      .out_valid (b_valid),
      .out_div   (b_div),
      .out_side  (b_side)
   );

   always_comb begin
      digit[0] = b_side.rem0;
      digit[1] = b_div.rem;
      digit[2] = b_div.nq[15:0];
      z_w = 16'd0;
      c_w = 16'd0;
      t_w = 16'd0;
      for (int i = 0; i < 3; i++) begin
         case (axis_of(b_side.order, 2'(i)))
            AXIS_Z:  z_w = digit[i] & CMASK;
            AXIS_C:  c_w = digit[i] & CMASK;
            default: t_w = digit[i] & CMASK;
         endcase
      end
      if (b_side.func) begin
         data_in = {t_w, c_w, z_w, 48'd0};
      end else begin
         data_in = {48'd0, b_side.index};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= data_in;
         rsp_err_ff  <= b_side.err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
`default_nettype wire

FILE: design/pizc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "plane_index_zct_converter_assert.svh"
module pizc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   `PIZC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `PIZC_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   `PIZC_ASSERT_NOW(a_one_mode, clock, reset, rsp_tvalid && rsp_tdata[47:0] != 48'd0, rsp_tdata[95:48] == 48'd0)
endmodule

bind plane_index_zct_converter pizc_checker u_pizc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

FILE: tb/plane_index_zct_converter_checker.sv
`timescale 1ns / 1ps
module plane_index_zct_converter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending
);
   import pizc_pkg::*;

   typedef struct packed {
      logic [47:0] index;
      logic [15:0] z;
      logic [15:0] c;
      logic [15:0] t;
      logic        err;
   } conv_result;

   logic [2:0]  order_q;
   logic [15:0] depth_q, chan_q, time_q;
   conv_result  expected_q[$];

   function automatic logic [1:0] axis_at(input logic [2:0] ord, input int pos);
      logic [1:0] a[3];
      case (ord)
         ORDER_ZTC: a = '{2'd0, 2'd2, 2'd1};
         ORDER_CZT: a = '{2'd1, 2'd0, 2'd2};
         ORDER_CTZ: a = '{2'd1, 2'd2, 2'd0};
         ORDER_TZC: a = '{2'd2, 2'd0, 2'd1};
         ORDER_TCZ: a = '{2'd2, 2'd1, 2'd0};
         default:   a = '{2'd0, 2'd1, 2'd2};
      endcase
      return a[pos];
   endfunction

   function automatic conv_result convert(input logic func, input logic [95:0] d);
      conv_result r;
      logic [63:0] sz[3];
      logic [63:0] co[3];
      logic [63:0] len0, len1, idx, dg[3];
      logic [1:0]  p[3];
      r = '0;
      sz[0] = depth_q; sz[1] = chan_q; sz[2] = time_q;
      for (int i = 0; i < 3; i++) begin
         if (sz[i] == 0) begin
            r.err = 1'b1;
            sz[i] = 1;
         end
         p[i] = axis_at(order_q, i);
      end
      len0 = sz[p[0]];
      len1 = sz[p[1]];
      if (!func) begin
         co[0] = d[15:0]; co[1] = d[31:16]; co[2] = d[47:32];
         for (int i = 0; i < 3; i++)
            if (co[i] >= sz[i]) r.err = 1'b1;
         idx = co[p[0]] + co[p[1]] * len0 + co[p[2]] * len0 * len1;
         if (idx > 64'hFFFF_FFFF_FFFF) r.err = 1'b1;
         r.index = idx[47:0];
      end else begin
         idx = {16'd0, d[95:48]};
         if (idx >= sz[0] * sz[1] * sz[2]) r.err = 1'b1;
         dg[0] = idx % len0;
         dg[1] = (idx / len0) % len1;
         dg[2] = (idx / len0) / len1;
         for (int i = 0; i < 3; i++) co[p[i]] = dg[i];
         r.z = co[0][15:0]; r.c = co[1][15:0]; r.t = co[2][15:0];
      end
      return r;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      conv_result e;
      if (reset) begin
         order_q <= ORDER_ZCT;
         depth_q <= 16'd1;
         chan_q <= 16'd1;
         time_q <= 16'd1;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[3:2])
               REG_AXIS_ORDER:    order_q <= csr_pwdata[2:0];
               REG_DEPTH_COUNT:   depth_q <= csr_pwdata[15:0];
               REG_CHANNEL_COUNT: chan_q <= csr_pwdata[15:0];
               REG_TIME_COUNT:    time_q <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_q.insert(expected_q.size(), convert(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result %h err %b", $time, rsp_tdata, rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_tdata !== {e.t, e.c, e.z, e.index} || rsp_tuser !== e.err) begin
                  $display("%0t mismatch: expected %h err %b, actual %h err %b", $time,
                     {e.t, e.c, e.z, e.index}, e.err, rsp_tdata, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: tb/plane_index_zct_converter_tb.sv
`timescale 1ns / 1ps
module plane_index_zct_converter_tb;
   import pizc_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending;
   int          cycle_count = 0;
   int          hold_off = 0;
   logic        hold_req = 0;
   logic        hold_done = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   plane_index_zct_converter dut (.*);
   plane_index_zct_converter_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: mostly random stalls, with one long hold-off on request.
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_off <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (cycle_count % 1000 < 300) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic send_request(input logic func, input logic [95:0] d);
      req_tvalid <= 1; req_tuser <= func; req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if ($urandom_range(0, 9) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_config(input logic [2:0] ord, input logic [15:0] dz,
                             input logic [15:0] dc, input logic [15:0] dt);
      write_reg(REG_AXIS_ORDER, {29'd0, ord});
      write_reg(REG_DEPTH_COUNT, {16'd0, dz});
      write_reg(REG_CHANNEL_COUNT, {16'd0, dc});
      write_reg(REG_TIME_COUNT, {16'd0, dt});
   endtask

   function automatic logic [15:0] rand_count();
      case ($urandom_range(0, 5))
         0: return 16'hFFFF;
         1: return 16'd1;
         2: return 16'd0;
         default: return 16'($urandom_range(1, 300));
      endcase
   endfunction

   function automatic logic [95:0] coords(input logic [15:0] z, input logic [15:0] c,
                                          input logic [15:0] t, input logic [47:0] ix);
      return {ix, t, c, z};
   endfunction

   initial begin
      logic [15:0] dz, dc, dt;
      logic [47:0] tot;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_request(0, coords(0, 0, 0, 0));
      send_request(1, coords(0, 0, 0, 0));
      drain();
      set_config(ORDER_CTZ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(0, coords(16'hFFFE, 16'hFFFE, 16'hFFFE, 0));
      send_request(0, coords(16'hFFFF, 16'hFFFF, 16'hFFFF, '1));
      send_request(1, coords('1, '1, '1, 48'hFFFF_FFFF_FFFF));
      send_request(1, coords(0, 0, 0, 48'hFFFD_0002_FFFE));
      drain();
      set_config(3'd7, 16'd0, 16'd5, 16'd3);
      send_request(0, coords(0, 4, 2, 0));
      send_request(1, coords(0, 0, 0, 48'd14));
      drain();
      set_config(3'd6, 16'd3, 16'd4, 16'd5);
      send_request(0, coords(2, 3, 4, 0));
      send_request(1, coords(0, 0, 0, 48'd60));
      drain();
      for (int phase = 0; phase < 11; phase++) begin
         dz = rand_count(); dc = rand_count(); dt = rand_count();
         set_config(3'($urandom_range(0, 7)), dz, dc, dt);
         tot = (dz == 0 ? 1 : dz) * (dc == 0 ? 1 : dc) * (dt == 0 ? 1 : dt);
         if (phase == 3) hold_req <= 1'b1;
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 1)) begin
               if ($urandom_range(0, 7) == 0)
                  send_request(0, coords(16'($urandom), 16'($urandom), 16'($urandom),
                     48'({$urandom, $urandom})));
               else
                  send_request(0, coords(16'($urandom_range(0, dz)),
                     16'($urandom_range(0, dc)), 16'($urandom_range(0, dt)),
                     48'({$urandom, $urandom})));
            end else begin
               if ($urandom_range(0, 7) == 0)
                  send_request(1, {48'({$urandom, $urandom}), 48'($urandom)});
               else
                  send_request(1, {48'({$urandom, $urandom}) % (tot + 48'd1),
                     16'($urandom), 32'($urandom)});
            end
         end
         drain();
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
